/* src/bbfa_pkg.sv */
// Package for the buddy best-fit allocator.
// Holds default sizes, the controller state type and the command and status structs.
// No dependencies.
package bbfa_pkg;

    // Default heap geometry and bit-map depth limit.
    localparam int HEAP_BYTES_DEF   = 65536;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int MAP_DEPTH        = 4096;

    // Width of the request size field.
    localparam int REQ_W  = 16;
    localparam int ADDR_W = 32;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_LAST,
        ST_DECIDE,
        ST_MARK,
        ST_SPLIT,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;
        logic accept;
        logic scan;
        logic fin;
        logic mark;
        logic split;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic found;
        logic split_stop;
        logic out_free;
    } status_t;

endpackage

/* src/bbfa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bbfa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/bbfa_datapath.sv */
// Datapath of the allocator: block map RAM, scan tracking, split arithmetic and output register.
// Depends on bbfa_pkg and bbfa_ram.
module bbfa_datapath #(
    parameter int HEAP_BYTES   = bbfa_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = bbfa_pkg::HEADER_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bbfa_pkg::cmd_t                 cmd,
    output bbfa_pkg::status_t              status,
    input  logic                           cfg_valid,
    input  logic [bbfa_pkg::ADDR_W-1:0]    cfg_data,
    input  logic [bbfa_pkg::REQ_W-1:0]     s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bbfa_pkg::ADDR_W-1:0]    m_tdata,
    output logic                           m_tuser
);

    localparam int ENTRIES = (HEAP_BYTES < bbfa_pkg::MAP_DEPTH) ? HEAP_BYTES
                                                                : bbfa_pkg::MAP_DEPTH;
    localparam int GSH = $clog2(HEAP_BYTES / ENTRIES);
    localparam int GW  = $clog2(ENTRIES);
    localparam int CW  = GW + 1;
    localparam int BW  = CW + GSH;
    localparam int NW  = (BW > bbfa_pkg::REQ_W + 1) ? BW : bbfa_pkg::REQ_W + 1;

    logic [GW-1:0]                 addr_reg, addr_next;
    logic [GW-1:0]                 pidx_reg;
    logic                          pv_reg;
    logic [GW-1:0]                 cur_reg;
    logic                          cur_free_reg;
    logic                          found_reg;
    logic [GW-1:0]                 best_reg;
    logic [CW-1:0]                 best_szg_reg;
    logic [CW-1:0]                 szg_reg;
    logic [bbfa_pkg::REQ_W-1:0]    req_reg;
    logic [bbfa_pkg::ADDR_W-1:0]   base_reg;
    logic                          m_tvalid_reg;
    logic [bbfa_pkg::ADDR_W-1:0]   m_tdata_reg;
    logic                          m_tuser_reg;

    logic          ram_we;
    logic [GW-1:0] ram_waddr;
    logic [1:0]    ram_wdata;
    logic [1:0]    ram_rdata;

    logic [CW-1:0] end_idx;
    logic [CW-1:0] blk_szg;
    logic [NW-1:0] blk_bytes;
    logic [NW-1:0] need;
    logic          fit;
    logic          eval_en;
    logic [NW-1:0] half_bytes;
    logic          stop;
    logic [GW-1:0] hg;

    // Each entry holds the start bit (bit 1) and the free bit (bit 0).
    bbfa_ram #(
        .WIDTH(2),
        .DEPTH(ENTRIES)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Evaluate a completed block against the request and the best so far.
    always_comb begin
        end_idx   = cmd.fin ? CW'(ENTRIES) : {1'b0, pidx_reg};
        blk_szg   = end_idx - {1'b0, cur_reg};
        blk_bytes = NW'(blk_szg) << GSH;
        need      = NW'(req_reg) + NW'(HEADER_BYTES);
        fit       = cur_free_reg && (blk_bytes >= need)
                    && (!found_reg || (blk_szg < best_szg_reg));
        eval_en   = cmd.fin || (pv_reg && (pidx_reg != '0) && ram_rdata[1]);
    end

    // Split arithmetic on the chosen block.
    always_comb begin
        half_bytes = (NW'(szg_reg) << GSH) >> 1;
        stop       = (szg_reg < CW'(2)) || (half_bytes <= need);
        hg         = best_reg + GW'(szg_reg >> 1);
    end

    // RAM write selection: clearing pass, mark used, or new free upper half.
    always_comb begin
        ram_we    = cmd.clr || cmd.mark || (cmd.split && !stop);
        ram_waddr = hg;
        ram_wdata = 2'b11;
        if (cmd.clr) begin
            ram_waddr = addr_reg;
            ram_wdata = {addr_reg == '0, addr_reg == '0};
        end else if (cmd.mark) begin
            ram_waddr = best_reg;
            ram_wdata = 2'b10;
        end
    end

    // Address counter for clearing and scanning.
    always_comb begin
        addr_next = addr_reg;
        if (cmd.accept) begin
            addr_next = '0;
        end else if (cmd.clr || cmd.scan) begin
            addr_next = addr_reg + GW'(1);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg     <= '0;
            pv_reg       <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            base_reg     <= '0;
        end else begin
            addr_reg <= addr_next;
            pv_reg   <= cmd.scan;
            if (cmd.accept) begin
                found_reg <= 1'b0;
            end else if (eval_en && fit) begin
                found_reg <= 1'b1;
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                base_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pidx_reg <= addr_reg;
        if (cmd.accept) begin
            req_reg <= s_tdata;
        end
        if (eval_en && fit) begin
            best_reg     <= cur_reg;
            best_szg_reg <= blk_szg;
        end
        if (pv_reg && ((pidx_reg == '0) || ram_rdata[1])) begin
            cur_reg      <= pidx_reg;
            cur_free_reg <= ram_rdata[0];
        end
        if (cmd.mark) begin
            szg_reg <= best_szg_reg;
        end else if (cmd.split && !stop) begin
            szg_reg <= szg_reg >> 1;
        end
        if (cmd.load_out) begin
            m_tuser_reg <= found_reg;
            m_tdata_reg <= found_reg
                ? base_reg + bbfa_pkg::ADDR_W'({best_reg, {GSH{1'b0}}})
                  + bbfa_pkg::ADDR_W'(HEADER_BYTES)
                : '0;
        end
    end

    // Status back to the controller.
    always_comb begin
        status.clr_last   = (addr_reg == GW'(ENTRIES - 1));
        status.scan_last  = (addr_reg == GW'(ENTRIES - 1));
        status.found      = found_reg;
        status.split_stop = stop;
        status.out_free   = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* src/bbfa_ctrl.sv */
// Controller state machine of the allocator: sequences clear, scan, mark, split and output.
// Depends on bbfa_pkg.
module bbfa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  bbfa_pkg::status_t status,
    output bbfa_pkg::cmd_t    cmd
);

    bbfa_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bbfa_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bbfa_pkg::ST_CLEAR: begin
                if (status.clr_last) state_next = bbfa_pkg::ST_IDLE;
            end
            bbfa_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = bbfa_pkg::ST_SCAN;
            end
            bbfa_pkg::ST_SCAN: begin
                if (status.scan_last) state_next = bbfa_pkg::ST_DRAIN;
            end
            bbfa_pkg::ST_DRAIN:  state_next = bbfa_pkg::ST_LAST;
            bbfa_pkg::ST_LAST:   state_next = bbfa_pkg::ST_DECIDE;
            bbfa_pkg::ST_DECIDE: begin
                state_next = status.found ? bbfa_pkg::ST_MARK : bbfa_pkg::ST_OUT;
            end
            bbfa_pkg::ST_MARK:   state_next = bbfa_pkg::ST_SPLIT;
            bbfa_pkg::ST_SPLIT: begin
                if (status.split_stop) state_next = bbfa_pkg::ST_OUT;
            end
            bbfa_pkg::ST_OUT: begin
                if (status.out_free) state_next = bbfa_pkg::ST_IDLE;
            end
            default: state_next = bbfa_pkg::ST_CLEAR;
        endcase
    end

    // Output decode.
    always_comb begin
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            bbfa_pkg::ST_CLEAR: cmd.clr = 1'b1;
            bbfa_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            bbfa_pkg::ST_SCAN:  cmd.scan  = 1'b1;
            bbfa_pkg::ST_LAST:  cmd.fin   = 1'b1;
            bbfa_pkg::ST_MARK:  cmd.mark  = 1'b1;
            bbfa_pkg::ST_SPLIT: cmd.split = 1'b1;
            bbfa_pkg::ST_OUT:   cmd.load_out = status.out_free;
            default: ;
        endcase
    end

endmodule

/* src/buddy_best_fit_allocator_core.sv */
// Buddy best-fit allocator core: one allocation item in, one result item out.
// ENTRIES = min(HEAP_BYTES, 4096). The granule-by-granule scan of the map RAM over all ENTRIES
// entries sets the time per item; a granted item then has its block marked used and split in
// halves until a half is no larger than the request plus header, while a refused item skips both.
// The result is loaded once the previous one is taken; only then is a new item accepted.
// Reset (aresetn low, synchronous) clears control state, then a clearing pass over every map entry rebuilds the map.
module buddy_best_fit_allocator_core #(
    parameter int HEAP_BYTES   = bbfa_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = bbfa_pkg::HEADER_BYTES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [31:0]                 cfg_data,   // heap_base
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,    // request_size
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,    // block_address
    output logic                        m_tuser     // granted
);

    bbfa_pkg::cmd_t    cmd;
    bbfa_pkg::status_t status;

    assign cfg_ready = 1'b1;

    // Controller.
    bbfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    bbfa_datapath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // A refused request returns a zero address.
    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 32'd0))
        else $error("refused item carries a nonzero address");

    // Accepting an item makes the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("block took a second item while busy");

    // A new result only appears after a busy cycle.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work in progress");
`endif

endmodule
